// ===== hdl/flto_pkg.sv =====
// Shared constants, command and status types and saturation helpers of the load-torque observer.
package flto_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INERTIA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BW       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd5;

	localparam logic [31:0] DEF_PERIOD   = 32'd4294967;
	localparam logic [30:0] DEF_KT       = 31'd3277;
	localparam logic [39:0] DEF_INERTIA  = 40'd10995116;
	localparam logic [30:0] DEF_FRICTION = 31'd0;
	localparam logic [23:0] DEF_BW       = 24'd25600;
	localparam logic [30:0] DEF_LIMIT    = 31'd32768;

	// Gains for the default configuration: 2*wo - B/J and -(J*wo^2 >> 32)
	localparam logic signed [47:0] RST_L1 = 48'sd13107200;
	localparam logic signed [47:0] RST_L2 = -48'sd1677721;

	// Shared arithmetic units
	localparam int MAG_W   = 63;
	localparam int MUL_B_W = 48;
	localparam int MUL_P_W = MAG_W + MUL_B_W;
	localparam int DEN_W   = 40;

	localparam logic [MAG_W-1:0] RPM_RAD = 63'd449767923;   // pi/30 in Q32
	localparam logic [MAG_W-1:0] CAP_47  = 63'd1 << 47;
	localparam logic [MAG_W-1:0] CAP_61  = 63'd1 << 61;
	localparam logic [MAG_W-1:0] CAP_62  = 63'd1 << 62;

	// Datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_OMEGA  = 4'd0;
	localparam logic [OP_W-1:0] OP_INIT   = 4'd1;
	localparam logic [OP_W-1:0] OP_ERR    = 4'd2;
	localparam logic [OP_W-1:0] OP_FW     = 4'd3;
	localparam logic [OP_W-1:0] OP_IQKT   = 4'd4;
	localparam logic [OP_W-1:0] OP_DIVACC = 4'd5;
	localparam logic [OP_W-1:0] OP_L1E    = 4'd6;
	localparam logic [OP_W-1:0] OP_DW     = 4'd7;
	localparam logic [OP_W-1:0] OP_L2E    = 4'd8;
	localparam logic [OP_W-1:0] OP_DT     = 4'd9;
	localparam logic [OP_W-1:0] OP_COMMIT = 4'd10;
	localparam logic [OP_W-1:0] OP_GDIV   = 4'd11;
	localparam logic [OP_W-1:0] OP_WO2    = 4'd12;
	localparam logic [OP_W-1:0] OP_L2G    = 4'd13;

	typedef struct packed {
		logic            go;
		logic [OP_W-1:0] op;
		logic            load_in;
		logic            cfg_we;
		logic            load_out;
	} flto_cmd_t;

	typedef struct packed {
		logic done;
		logic reinit;
	} flto_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (v < -65'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
		if (v > 50'sd140737488355327)
			return 48'h7FFF_FFFF_FFFF;
		else if (v < -50'sd140737488355328)
			return 48'h8000_0000_0000;
		else
			return v[47:0];
	endfunction

endpackage

// ===== hdl/flto_if.sv =====
// Valid/ready channel interfaces of the load-torque observer.
interface flto_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [15:0] phase_current;
	logic signed [15:0] shaft_speed;
	modport source(output valid, req_type, phase_current, shaft_speed, input ready);
	modport sink(input valid, req_type, phase_current, shaft_speed, output ready);
endinterface

interface flto_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] torque_estimate;
	logic signed [31:0] speed_estimate_out;
	logic signed [31:0] speed_error;
	modport source(output valid, torque_estimate, speed_estimate_out, speed_error, input ready);
	modport sink(input valid, torque_estimate, speed_estimate_out, speed_error, output ready);
endinterface

interface flto_cfg_if import flto_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/flto_mul.sv =====
// Shift-add multiplier, one bit of b per cycle, with right shift and saturation of the product.
module flto_mul import flto_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MAG_W-1:0]   a,
	input  logic [MUL_B_W-1:0] b,
	input  logic [5:0]         sh,
	input  logic [MAG_W-1:0]   cap,
	output logic               done,
	output logic [MAG_W-1:0]   res
);
	logic [MAG_W-1:0]   a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_P_W-1:0] p_q;
	logic [5:0]         sh_q;
	logic [MAG_W-1:0]   cap_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic               fin_q;
	logic               last;
	logic [MUL_P_W-1:0] shifted;

	assign last    = busy_q && (cnt_q == 6'(MUL_B_W - 1));
	assign shifted = p_q >> sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done   <= 1'b0;
		end else begin
			done  <= fin_q;
			fin_q <= last;
			if (start)
				busy_q <= 1'b1;
			else if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			sh_q  <= sh;
			cap_q <= cap;
			p_q   <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			p_q   <= {p_q[MUL_P_W-2:0], 1'b0} + (b_q[MUL_B_W-1] ? MUL_P_W'(a_q) : '0);
			b_q   <= {b_q[MUL_B_W-2:0], 1'b0};
			cnt_q <= cnt_q + 6'd1;
		end
		if (fin_q)
			res <= (shifted > MUL_P_W'(cap_q)) ? cap_q : shifted[MAG_W-1:0];
	end
endmodule

// ===== hdl/flto_div.sv =====
// Restoring divider, one quotient bit per cycle, of num * 2^sh by den with saturation.
module flto_div import flto_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] num,
	input  logic [5:0]       sh,
	input  logic [DEN_W-1:0] den,
	input  logic [MAG_W-1:0] cap,
	output logic             done,
	output logic [MAG_W-1:0] res
);
	logic [MAG_W-1:0] n_q;
	logic [DEN_W-1:0] d_q;
	logic [DEN_W-1:0] r_q;
	logic [MAG_W-1:0] q_q;
	logic [MAG_W-1:0] cap_q;
	logic             ovf_q;
	logic [6:0]       cnt_q;
	logic [6:0]       end_q;
	logic             busy_q;
	logic             fin_q;
	logic             last;
	logic [DEN_W:0]   rs;
	logic             ge;

	assign last = busy_q && (cnt_q == end_q);
	assign rs   = {r_q, n_q[MAG_W-1]};
	assign ge   = rs >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done   <= 1'b0;
		end else begin
			done  <= fin_q;
			fin_q <= last;
			if (start)
				busy_q <= 1'b1;
			else if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			cap_q <= cap;
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
			end_q <= 7'(MAG_W) + {1'b0, sh} - 7'd1;
		end else if (busy_q) begin
			n_q   <= {n_q[MAG_W-2:0], 1'b0};
			r_q   <= ge ? DEN_W'(rs - {1'b0, d_q}) : rs[DEN_W-1:0];
			q_q   <= {q_q[MAG_W-2:0], ge};
			cnt_q <= cnt_q + 7'd1;
			// quotient already past 2^62: it can only end above the cap
			if (q_q[MAG_W-1])
				ovf_q <= 1'b1;
		end
		if (fin_q)
			res <= (ovf_q || q_q > cap_q) ? cap_q : q_q;
	end
endmodule

// ===== hdl/flto_dp.sv =====
// Observer datapath: configuration, gains, estimates, operand selection and the shared units.
module flto_dp import flto_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  flto_cmd_t             cmd,
	output flto_sts_t             sts,
	input  logic                  req_type,
	input  logic signed [15:0]    phase_current,
	input  logic signed [15:0]    shaft_speed,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic signed [31:0]    torque_estimate,
	output logic signed [31:0]    speed_estimate_out,
	output logic signed [31:0]    speed_error
);
	// configuration and derived gains
	logic [31:0]        per_q;
	logic [30:0]        kt_q;
	logic [39:0]        j_q;
	logic [30:0]        fr_q;
	logic [23:0]        bw_q;
	logic [30:0]        lim_q;
	logic signed [47:0] l1_q;
	logic signed [47:0] l2_q;
	logic [47:0]        wo2_q;
	// estimates
	logic signed [31:0] w_q;
	logic signed [31:0] t_q;
	// working registers of one tick
	logic               reinit_q;
	logic signed [15:0] iq_q;
	logic signed [15:0] rpm_q;
	logic signed [31:0] omega_q;
	logic signed [31:0] err_q;
	logic signed [47:0] fw_q;
	logic signed [55:0] num_q;
	logic signed [63:0] acc_q;
	logic signed [62:0] tdot_q;
	logic signed [31:0] wn_q;
	logic signed [31:0] tn_q;
	logic [OP_W-1:0]    cur_op_q;

	logic               mul_go, div_go, mul_done, div_done, wb;
	logic [MAG_W-1:0]   mul_a, mul_res, div_num, div_res, res, mul_cap, div_cap;
	logic [MUL_B_W-1:0] mul_b;
	logic [5:0]         mul_sh, div_sh;
	logic               neg;
	logic signed [63:0] sres;
	logic signed [63:0] num_nxt;
	logic signed [49:0] l1_nxt;
	logic signed [31:0] t_sum;
	logic signed [32:0] lim_s;
	logic signed [31:0] t_clamp;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	assign mul_go = cmd.go && (cmd.op inside {OP_OMEGA, OP_FW, OP_IQKT, OP_L1E, OP_DW,
		OP_L2E, OP_DT, OP_WO2, OP_L2G});
	assign div_go = cmd.go && (cmd.op inside {OP_DIVACC, OP_GDIV});

	// operand selection for the unit being launched
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_sh  = 6'd0;
		mul_cap = CAP_62;
		div_num = '0;
		div_sh  = 6'd0;
		div_cap = CAP_61;
		case (cmd.op)
			OP_OMEGA: begin
				mul_a = RPM_RAD;
				mul_b = MUL_B_W'(mag64(64'(rpm_q)));
				mul_sh = 6'd16;
			end
			OP_FW: begin
				mul_a = MAG_W'(mag64(64'(w_q)));
				mul_b = MUL_B_W'(fr_q);
				mul_sh = 6'd16;
			end
			OP_IQKT: begin
				mul_a = MAG_W'(kt_q);
				mul_b = MUL_B_W'(mag64(64'(iq_q)));
			end
			OP_DIVACC: begin
				div_num = MAG_W'(mag64(64'(num_q)));
				div_sh  = 6'd40;
			end
			OP_L1E: begin
				mul_a   = MAG_W'(mag64(64'(l1_q)));
				mul_b   = MUL_B_W'(mag64(64'(err_q)));
				mul_cap = CAP_61;
			end
			OP_DW: begin
				mul_a   = MAG_W'(mag64(acc_q));
				mul_b   = MUL_B_W'(per_q);
				mul_sh  = 6'd48;
				mul_cap = CAP_61;
			end
			OP_L2E: begin
				mul_a   = MAG_W'(mag64(64'(l2_q)));
				mul_b   = MUL_B_W'(mag64(64'(err_q)));
				mul_sh  = 6'd8;
				mul_cap = CAP_61;
			end
			OP_DT: begin
				mul_a   = MAG_W'(mag64(64'(tdot_q)));
				mul_b   = MUL_B_W'(per_q);
				mul_sh  = 6'd48;
				mul_cap = CAP_61;
			end
			OP_GDIV: begin
				div_num = MAG_W'(fr_q);
				div_sh  = 6'd24;
				div_cap = CAP_47;
			end
			OP_WO2: begin
				mul_a = MAG_W'(bw_q);
				mul_b = MUL_B_W'(bw_q);
			end
			OP_L2G: begin
				mul_a   = MAG_W'(j_q);
				mul_b   = wo2_q;
				mul_sh  = 6'd32;
				mul_cap = CAP_47;
			end
			default: ;
		endcase
	end

	flto_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(mul_a), .b(mul_b), .sh(mul_sh),
		.cap(mul_cap), .done(mul_done), .res(mul_res)
	);

	flto_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(div_num), .sh(div_sh), .den(j_q),
		.cap(div_cap), .done(div_done), .res(div_res)
	);

	assign wb  = mul_done || div_done;
	assign res = mul_done ? mul_res : div_res;

	// sign of the finished product or quotient
	always_comb begin
		case (cur_op_q)
			OP_OMEGA:  neg = rpm_q[15];
			OP_FW:     neg = w_q[31];
			OP_IQKT:   neg = iq_q[15];
			OP_DIVACC: neg = num_q[55];
			OP_L1E:    neg = l1_q[47] ^ err_q[31];
			OP_DW:     neg = acc_q[63];
			OP_L2E:    neg = l2_q[47] ^ err_q[31];
			OP_DT:     neg = tdot_q[62];
			OP_L2G:    neg = 1'b1;
			default:   neg = 1'b0;
		endcase
	end

	assign sres    = neg ? -$signed({1'b0, res}) : $signed({1'b0, res});
	assign num_nxt = -64'(fw_q) + (sres <<< 6) - (64'(t_q) <<< 16);
	assign l1_nxt  = $signed({17'd0, bw_q, 9'd0}) - $signed({2'b00, res[47:0]});
	assign t_sum   = sat32(65'(t_q) + 65'(sres));
	assign lim_s   = $signed({2'b00, lim_q});

	always_comb begin
		t_clamp = t_sum;
		if (lim_q != '0) begin
			if (33'(t_sum) > lim_s)
				t_clamp = 32'(lim_s);
			else if (33'(t_sum) < -lim_s)
				t_clamp = 32'(-lim_s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q <= DEF_PERIOD;
			kt_q  <= DEF_KT;
			j_q   <= DEF_INERTIA;
			fr_q  <= DEF_FRICTION;
			bw_q  <= DEF_BW;
			lim_q <= DEF_LIMIT;
			l1_q  <= RST_L1;
			l2_q  <= RST_L2;
			w_q   <= '0;
			t_q   <= '0;
		end else begin
			if (cmd.cfg_we) begin
				case (cfg_index)
					REG_PERIOD:   per_q <= (cfg_data[31:0] == '0) ? DEF_PERIOD : cfg_data[31:0];
					REG_KT:       kt_q  <= (cfg_data[30:0] == '0) ? DEF_KT : cfg_data[30:0];
					REG_INERTIA:  j_q   <= (cfg_data[39:0] == '0) ? DEF_INERTIA : cfg_data[39:0];
					REG_FRICTION: fr_q  <= cfg_data[30:0];
					REG_BW:       bw_q  <= (cfg_data[23:0] == '0) ? DEF_BW : cfg_data[23:0];
					REG_LIMIT:    lim_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (cmd.go) begin
				case (cmd.op)
					OP_INIT: begin
						w_q <= omega_q;
						t_q <= '0;
					end
					OP_COMMIT: begin
						w_q <= wn_q;
						t_q <= tn_q;
					end
					default: ;
				endcase
			end
			if (wb) begin
				case (cur_op_q)
					OP_GDIV: l1_q <= sat48(l1_nxt);
					OP_L2G:  l2_q <= 48'(sres);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			reinit_q <= req_type;
			iq_q     <= phase_current;
			rpm_q    <= shaft_speed;
		end
		if (cmd.go) begin
			cur_op_q <= cmd.op;
			if (cmd.op == OP_ERR)
				err_q <= sat32(65'(omega_q) - 65'(w_q));
		end
		if (wb) begin
			case (cur_op_q)
				OP_OMEGA:  omega_q <= 32'(sres);
				OP_FW:     fw_q    <= 48'(sres);
				OP_IQKT:   num_q   <= 56'(num_nxt);
				OP_DIVACC: acc_q   <= sres;
				OP_L1E:    acc_q   <= acc_q + sres;
				OP_DW:     wn_q    <= sat32(65'(w_q) + 65'(sres));
				OP_L2E:    tdot_q  <= 63'(sres);
				OP_DT:     tn_q    <= t_clamp;
				OP_WO2:    wo2_q   <= res[47:0];
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			torque_estimate    <= t_q;
			speed_estimate_out <= w_q;
			speed_error        <= reinit_q ? '0 : err_q;
		end
	end

	assign sts.done   = wb;
	assign sts.reinit = reinit_q;
endmodule

// ===== hdl/flto_ctrl.sv =====
// Observer sequencer: steps the datapath through a tick, a re-initialization or a gain update.
module flto_ctrl import flto_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  flto_sts_t sts,
	output flto_cmd_t cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_OMEGA  = 4'd1;
	localparam logic [3:0] S_INIT   = 4'd2;
	localparam logic [3:0] S_ERR    = 4'd3;
	localparam logic [3:0] S_FW     = 4'd4;
	localparam logic [3:0] S_IQKT   = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_L1E    = 4'd7;
	localparam logic [3:0] S_DW     = 4'd8;
	localparam logic [3:0] S_L2E    = 4'd9;
	localparam logic [3:0] S_DT     = 4'd10;
	localparam logic [3:0] S_COMMIT = 4'd11;
	localparam logic [3:0] S_OUT    = 4'd12;
	localparam logic [3:0] S_GDIV   = 4'd13;
	localparam logic [3:0] S_WO2    = 4'd14;
	localparam logic [3:0] S_L2G    = 4'd15;

	logic [3:0] state_q, state_nxt;
	logic       launched_q;
	logic       primed_q;
	logic       rsp_valid_q;
	logic       rsp_free;

	assign cfg_ready = (state_q == S_IDLE);
	assign req_ready = (state_q == S_IDLE) && !cfg_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					cmd.cfg_we = 1'b1;
					state_nxt  = S_GDIV;
				end else if (req_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = S_OMEGA;
				end
			end
			S_OMEGA: begin
				cmd.go = !launched_q;
				cmd.op = OP_OMEGA;
				if (sts.done)
					state_nxt = (sts.reinit || !primed_q) ? S_INIT : S_ERR;
			end
			S_INIT: begin
				cmd.go    = 1'b1;
				cmd.op    = OP_INIT;
				state_nxt = sts.reinit ? S_OUT : S_ERR;
			end
			S_ERR: begin
				cmd.go    = 1'b1;
				cmd.op    = OP_ERR;
				state_nxt = S_FW;
			end
			S_FW: begin
				cmd.go = !launched_q;
				cmd.op = OP_FW;
				if (sts.done)
					state_nxt = S_IQKT;
			end
			S_IQKT: begin
				cmd.go = !launched_q;
				cmd.op = OP_IQKT;
				if (sts.done)
					state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.go = !launched_q;
				cmd.op = OP_DIVACC;
				if (sts.done)
					state_nxt = S_L1E;
			end
			S_L1E: begin
				cmd.go = !launched_q;
				cmd.op = OP_L1E;
				if (sts.done)
					state_nxt = S_DW;
			end
			S_DW: begin
				cmd.go = !launched_q;
				cmd.op = OP_DW;
				if (sts.done)
					state_nxt = S_L2E;
			end
			S_L2E: begin
				cmd.go = !launched_q;
				cmd.op = OP_L2E;
				if (sts.done)
					state_nxt = S_DT;
			end
			S_DT: begin
				cmd.go = !launched_q;
				cmd.op = OP_DT;
				if (sts.done)
					state_nxt = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.go    = 1'b1;
				cmd.op    = OP_COMMIT;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				// hold until the output register is free
				if (rsp_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_GDIV: begin
				cmd.go = !launched_q;
				cmd.op = OP_GDIV;
				if (sts.done)
					state_nxt = S_WO2;
			end
			S_WO2: begin
				cmd.go = !launched_q;
				cmd.op = OP_WO2;
				if (sts.done)
					state_nxt = S_L2G;
			end
			S_L2G: begin
				cmd.go = !launched_q;
				cmd.op = OP_L2G;
				if (sts.done)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launched_q  <= 1'b0;
			primed_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// rearm on every step so each unit state launches once
			if (sts.done || (state_nxt != state_q))
				launched_q <= 1'b0;
			else if (cmd.go)
				launched_q <= 1'b1;
			if (state_q == S_INIT)
				primed_q <= 1'b1;
			if (cmd.load_out)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end
endmodule

// ===== hdl/full_order_load_torque_observer_top.sv =====
// Full-order load-torque observer: top level joining the sequencer and the datapath.
//
// Each request word is an observer tick or a re-initialization. A tick converts the
// measured speed from rpm to rad/s, forms the speed error, and advances the speed and
// load-torque estimates by one forward-Euler step; a re-initialization loads the
// measured speed and a zero torque and answers with them. Arithmetic runs on one
// shared shift-add multiplier (one multiplier bit per cycle) and one restoring
// divider (one quotient bit per cycle). A tick runs seven products and one division
// by the inertia, back to back. A configuration write re-derives both observer gains
// (one division and two products); no request word is taken during that time. The
// response sits in an output register, so a new request is taken while the previous
// response still waits.
module full_order_load_torque_observer_top import flto_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	flto_req_if.sink   req,
	flto_rsp_if.source rsp,
	flto_cfg_if.sink   cfg
);
	flto_cmd_t cmd;
	flto_sts_t sts;

	// sequencer: owns handshakes and the step order
	flto_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.cfg_valid(cfg.valid),
		.cfg_ready(cfg.ready),
		.sts(sts),
		.cmd(cmd)
	);

	// datapath: registers, gains, estimates and the shared units
	flto_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.req_type(req.req_type),
		.phase_current(req.phase_current),
		.shaft_speed(req.shaft_speed),
		.cfg_index(cfg.index),
		.cfg_data(cfg.data),
		.torque_estimate(rsp.torque_estimate),
		.speed_estimate_out(rsp.speed_estimate_out),
		.speed_error(rsp.speed_error)
	);
endmodule

// ===== hdl/flto_chk.sv =====
// Port-level checker of the load-torque observer and its bind to the top level.
module flto_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_torque,
	input logic [31:0] rsp_speed,
	input logic [31:0] rsp_err,
	input logic        cfg_valid,
	input logic        cfg_ready
);
	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_torque) &&
		$stable(rsp_speed) && $stable(rsp_err))
		else $error("stalled response changed");

	// one request word in flight at a time
	a_req_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// gain update blocks both channels
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !req_ready && !cfg_ready)
		else $error("channel open during gain update");

	// a request word and a register write never land on the same edge
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !(cfg_valid && cfg_ready))
		else $error("request and register write taken together");
endmodule

bind full_order_load_torque_observer_top flto_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_torque(rsp.torque_estimate),
	.rsp_speed(rsp.speed_estimate_out),
	.rsp_err(rsp.speed_error),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready)
);
